>>> src/uer_pkg.sv
// Package: shared types, register indexes and constants for the echo ranger.
`default_nettype none
package uer_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned COUNT_W    = 17;
    localparam int unsigned DIST_W     = 11;
    localparam int unsigned PAT_W      = 8;

    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_TIMEOUT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_FAR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_MID  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_NEAR = 3'd4;

    localparam logic [7:0]        RST_TRIGGER_LENGTH = 8'd10;
    localparam logic [15:0]       RST_ECHO_TIMEOUT   = 16'd30000;
    localparam logic [DIST_W-1:0] RST_THRESHOLD_FAR  = 11'd40;
    localparam logic [DIST_W-1:0] RST_THRESHOLD_MID  = 11'd25;
    localparam logic [DIST_W-1:0] RST_THRESHOLD_NEAR = 11'd10;

    localparam logic [PAT_W-1:0] PAT_FAR    = 8'h01;
    localparam logic [PAT_W-1:0] PAT_MID    = 8'h0F;
    localparam logic [PAT_W-1:0] PAT_NEAR   = 8'h7F;
    localparam logic [PAT_W-1:0] PAT_CLOSE  = 8'hFF;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef struct packed {
        logic [7:0]        trigger_length;
        logic [15:0]       echo_timeout;
        logic [DIST_W-1:0] threshold_far;
        logic [DIST_W-1:0] threshold_mid;
        logic [DIST_W-1:0] threshold_near;
    } uer_cfg_t;

    typedef struct packed {
        logic              trigger_level;
        logic              busy_res;
        logic              done_res;
        logic [DIST_W-1:0] distance_cm;
        logic              limit_reached;
        logic [PAT_W-1:0]  bar_pattern;
    } uer_res_t;

    function automatic logic [PAT_W-1:0] pick_pattern(input logic [DIST_W-1:0] d,
                                                      input uer_cfg_t cfg);
        logic [PAT_W-1:0] p;
        if (d > cfg.threshold_far)
            p = PAT_FAR;
        else if (d > cfg.threshold_mid)
            p = PAT_MID;
        else if (d > cfg.threshold_near)
            p = PAT_NEAR;
        else
            p = PAT_CLOSE;
        return p;
    endfunction

endpackage
`default_nettype wire

>>> src/uer_tick_if.sv
// Interface: input tick channel (start request and sampled echo level).
`default_nettype none
interface uer_tick_if;
    logic valid;
    logic ready;
    logic start_req;
    logic echo_level;

    modport source (output valid, output start_req, output echo_level, input ready);
    modport sink   (input valid, input start_req, input echo_level, output ready);
endinterface
`default_nettype wire

>>> src/uer_res_if.sv
// Interface: result channel (trigger, status and held measurement).
`default_nettype none
interface uer_res_if;
    logic        valid;
    logic        ready;
    logic        trigger_level;
    logic        busy_res;
    logic        done_res;
    logic [10:0] distance_cm;
    logic        limit_reached;
    logic [7:0]  bar_pattern;

    modport source (output valid, output trigger_level, output busy_res, output done_res,
                    output distance_cm, output limit_reached, output bar_pattern,
                    input ready);
    modport sink   (input valid, input trigger_level, input busy_res, input done_res,
                    input distance_cm, input limit_reached, input bar_pattern,
                    output ready);
endinterface
`default_nettype wire

>>> src/uer_cfg_regs.sv
// Configuration register file with reset defaults.
`default_nettype none
module uer_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [uer_pkg::CFG_DATA_W-1:0] cfg_data,
    output uer_pkg::uer_cfg_t                   cfg
);
    import uer_pkg::*;

    uer_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_length <= RST_TRIGGER_LENGTH;
            cfg_reg.echo_timeout   <= RST_ECHO_TIMEOUT;
            cfg_reg.threshold_far  <= RST_THRESHOLD_FAR;
            cfg_reg.threshold_mid  <= RST_THRESHOLD_MID;
            cfg_reg.threshold_near <= RST_THRESHOLD_NEAR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TRIGGER_LENGTH: cfg_reg.trigger_length <= cfg_data[7:0];
                REG_ECHO_TIMEOUT:   cfg_reg.echo_timeout   <= cfg_data;
                REG_THRESHOLD_FAR:  cfg_reg.threshold_far  <= cfg_data[DIST_W-1:0];
                REG_THRESHOLD_MID:  cfg_reg.threshold_mid  <= cfg_data[DIST_W-1:0];
                REG_THRESHOLD_NEAR: cfg_reg.threshold_near <= cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

>>> src/uer_engine.sv
// Measurement engine: phase sequencer, tick counter and running distance quotient.
`default_nettype none
module uer_engine #(
    parameter int unsigned TICKS_PER_CM = 44
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic       start_req,
    input  wire logic       echo_level,
    input  wire uer_pkg::uer_cfg_t cfg,
    output uer_pkg::uer_res_t res
);
    import uer_pkg::*;

    localparam int unsigned REM_W = (TICKS_PER_CM < 2) ? 1 : $clog2(TICKS_PER_CM + 1);
    localparam logic [REM_W-1:0] TPC = REM_W'(TICKS_PER_CM);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_TRIG  = 2'd1,
        PH_WAIT  = 2'd2,
        PH_COUNT = 2'd3
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [COUNT_W-1:0]  quot_reg, quot_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [DIST_W-1:0]   dist_reg, dist_next;
    logic [PAT_W-1:0]    pat_reg, pat_next;
    logic                limit_reg, limit_next;

    logic [7:0]          trig_len;
    logic [COUNT_W-1:0]  count_inc;
    logic [REM_W-1:0]    rem_inc;
    logic                rem_wrap;
    logic                first_wrap;
    logic [COUNT_W-1:0]  echo_count;
    logic [COUNT_W-1:0]  echo_quot;
    logic [REM_W-1:0]    echo_rem;
    logic                over;
    logic                finish;
    logic [COUNT_W-1:0]  fin_quot;
    logic [DIST_W-1:0]   fin_dist;
    logic                trig;
    logic                done;

    // Quotient and remainder track count / TICKS_PER_CM one tick at a time.
    assign trig_len   = (cfg.trigger_length == 8'd0) ? 8'd1 : cfg.trigger_length;
    assign count_inc  = count_reg + COUNT_W'(1);
    assign rem_inc    = rem_reg + REM_W'(1);
    assign rem_wrap   = (rem_inc == TPC);
    assign first_wrap = (TPC == REM_W'(1));
    assign echo_count = (phase_reg == PH_WAIT) ? COUNT_W'(1) : count_inc;
    assign echo_quot  = (phase_reg == PH_WAIT) ? (first_wrap ? COUNT_W'(1) : '0)
                                               : (rem_wrap ? quot_reg + COUNT_W'(1) : quot_reg);
    assign echo_rem   = (phase_reg == PH_WAIT) ? (first_wrap ? '0 : REM_W'(1))
                                               : (rem_wrap ? '0 : rem_inc);
    assign over       = echo_count > {1'b0, cfg.echo_timeout};
    assign fin_quot   = echo_level ? echo_quot : quot_reg;
    assign fin_dist   = (|fin_quot[COUNT_W-1:DIST_W]) ? DIST_MAX : fin_quot[DIST_W-1:0];

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        finish     = 1'b0;
        trig       = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start_req)
                begin
                    trig       = 1'b1;
                    count_next = COUNT_W'(1);
                    phase_next = (trig_len == 8'd1) ? PH_WAIT : PH_TRIG;
                end
            end
            PH_TRIG:
            begin
                trig       = 1'b1;
                count_next = count_inc;
                if (count_inc >= COUNT_W'(trig_len))
                    phase_next = PH_WAIT;
            end
            PH_WAIT:
            begin
                if (echo_level)
                begin
                    count_next = echo_count;
                    quot_next  = echo_quot;
                    rem_next   = echo_rem;
                    phase_next = PH_COUNT;
                    finish     = over;
                end
            end
            PH_COUNT:
            begin
                if (echo_level)
                begin
                    count_next = echo_count;
                    quot_next  = echo_quot;
                    rem_next   = echo_rem;
                    finish     = over;
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            default: ;
        endcase
        if (finish)
            phase_next = PH_IDLE;
    end

    assign done       = finish;
    assign dist_next  = finish ? fin_dist : dist_reg;
    assign pat_next   = finish ? pick_pattern(fin_dist, cfg) : pat_reg;
    assign limit_next = finish ? echo_level : limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            quot_reg  <= '0;
            rem_reg   <= '0;
            dist_reg  <= '0;
            pat_reg   <= '0;
            limit_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            quot_reg  <= quot_next;
            rem_reg   <= rem_next;
            dist_reg  <= dist_next;
            pat_reg   <= pat_next;
            limit_reg <= limit_next;
        end
    end

    assign res.trigger_level = trig;
    assign res.busy_res      = (phase_next != PH_IDLE);
    assign res.done_res      = done;
    assign res.distance_cm   = dist_next;
    assign res.limit_reached = limit_next;
    assign res.bar_pattern   = pat_next;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res.done_res |-> !res.busy_res)
        else $error("done beat reports busy");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg < TPC || TPC == '0)
        else $error("distance remainder out of range");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && done |=> phase_reg == PH_IDLE)
        else $error("measurement finished but phase not idle");

    a_count_low_done: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_COUNT && !echo_level |=> $past(done) && phase_reg == PH_IDLE)
        else $error("echo fall did not finish measurement");

endmodule
`default_nettype wire

>>> src/ultrasonic_echo_ranger_top.sv
// Top level: ultrasonic echo ranger with tick input, result register and config port.
//
//  channel | dir | handshake      | payload
//  tick    | in  | valid/ready    | start_req, echo_level
//  res     | out | valid/ready    | trigger_level, busy_res, done_res, distance_cm,
//          |     |                | limit_reached, bar_pattern
//  cfg     | in  | cfg_we         | cfg_index, cfg_data
//
// One tick beat per clock unless stalled; its result beat goes into the output register.
// tick.ready is high while the output register is empty or being emptied that cycle.
// Distance is kept as a running quotient and remainder, so no divider is needed.
// rst_n clears phase, counters, held results and output valid; config returns to defaults.
`default_nettype none
module ultrasonic_echo_ranger_top #(
    parameter int unsigned TICKS_PER_CM = 44
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    uer_tick_if.sink                            tick,
    uer_res_if.source                           res,
    input  wire logic                           cfg_we,
    input  wire logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [uer_pkg::CFG_DATA_W-1:0] cfg_data
);
    import uer_pkg::*;

    uer_cfg_t cfg;
    uer_res_t res_comb;
    uer_res_t res_reg;
    logic     res_valid_reg;
    logic     step;

    assign tick.ready = !res_valid_reg || res.ready;
    assign step       = tick.valid && tick.ready;

    uer_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    uer_engine #(
        .TICKS_PER_CM (TICKS_PER_CM)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .start_req  (tick.start_req),
        .echo_level (tick.echo_level),
        .cfg        (cfg),
        .res        (res_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (tick.ready)
            res_valid_reg <= tick.valid;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res_comb;
    end

    assign res.valid         = res_valid_reg;
    assign res.trigger_level = res_reg.trigger_level;
    assign res.busy_res      = res_reg.busy_res;
    assign res.done_res      = res_reg.done_res;
    assign res.distance_cm   = res_reg.distance_cm;
    assign res.limit_reached = res_reg.limit_reached;
    assign res.bar_pattern   = res_reg.bar_pattern;

endmodule
`default_nettype wire
